// ===== rtl/bbra_pkg.sv =====
package bbra_pkg;

    // field widths of the payload and configuration registers
    localparam int FUNC_W    = 2;
    localparam int RUN_W     = 7;
    localparam int IDX_W     = 12;
    localparam int STAT_W    = 2;
    localparam int FDB_W     = 12;
    localparam int LIM_CFG_W = 13;
    localparam int WORD_W    = 32;
    localparam int CHUNK_W   = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int DEF_NUM_BLOCKS = 4096;
    localparam int MAX_RUN        = 64;

    localparam logic [FDB_W-1:0]     FDB_RESET = FDB_W'(2);
    localparam logic [LIM_CFG_W-1:0] LIM_RESET = LIM_CFG_W'(4096);

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;

    // register index, taken from paddr bit 2
    localparam logic CFG_IDX_FDB = 1'b0;
    localparam logic CFG_IDX_LIM = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [RUN_W-1:0]  run_wanted;
        logic [IDX_W-1:0]  block_index;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  start_block;
        logic [RUN_W-1:0]  run_granted;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FILL_RD,
        ST_FILL_WB,
        ST_MARK_WB,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/bitmap_block_run_allocator.sv =====
// First-fit allocator of contiguous block runs over a used/free bitmap.
// Input channel s_*: one beat carries func, run_wanted and block_index.
// Result channel m_*: exactly one beat per input beat, in order.
// Configuration: APB port, first_data_block at 0x0, block_limit at 0x4;
// write only while the block is idle.
// The bitmap sits in one single-port-read, single-port-write memory of
// NUM_BLOCKS/32 words. An allocate scans the word under the search pointer
// eight blocks per cycle, then reads and writes back each word that the
// granted run touches (up to 3 for a 64-block run) to mark the run used.
// A mark used/free goes through decode, read and write back.
// The result is held in an output register: a new beat is taken while an
// earlier result waits for m_ready, but the next result waits until the
// output register frees up.
// After reset the memory is swept to all free, one word per cycle, and
// s_ready stays low until the sweep ends; config writes are taken.
module bitmap_block_run_allocator #(
    parameter int NUM_BLOCKS = bbra_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bbra_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bbra_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bbra_pkg::PADDR_W-1:0]  paddr,
    input  logic [bbra_pkg::PDATA_W-1:0]  pwdata,
    output logic [bbra_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import bbra_pkg::*;

    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int LIM_W     = $clog2(NUM_BLOCKS + 1);
    // block positions: hold the limit plus a chunk of overshoot
    localparam int POS_W     = (LIM_W + 1 > LIM_CFG_W + 1) ? LIM_W + 1 : LIM_CFG_W + 1;

    // bitmap memory, a set bit marks a used block
    logic [WORD_W-1:0] mem [MAP_WORDS];
    logic [WORD_W-1:0] q_reg;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [FDB_W-1:0]     fdb_reg;
    logic [LIM_CFG_W-1:0] lim_reg;

    logic [FUNC_W-1:0] func_reg, func_next;
    logic [RUN_W-1:0]  want_reg, want_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [RUN_W-1:0]  run_len_reg, run_len_next;
    logic [POS_W-1:0]  run_start_reg, run_start_next;
    logic [RUN_W-1:0]  best_reg, best_next;
    logic [POS_W-1:0]  best_start_reg, best_start_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic [POS_W-1:0]  lim_ext;
    logic [POS_W-1:0]  lim_eff;
    logic [POS_W-1:0]  fdb_pos;
    logic [POS_W-1:0]  idx_pos;
    logic [RUN_W-1:0]  want_sat;
    logic              start_none;
    logic              idx_in_map;

    // chunk scan
    logic [POS_W-1:0]   chunk_base;
    logic [CHUNK_W-1:0] chunk_free;
    logic [RUN_W-1:0]   cs_run_len;
    logic [POS_W-1:0]   cs_run_start;
    logic [RUN_W-1:0]   cs_best;
    logic [POS_W-1:0]   cs_best_start;
    logic               cs_done;

    // run fill
    logic [POS_W-1:0]  fill_end;
    logic [ADDR_W-1:0] fill_first_w;
    logic [ADDR_W-1:0] fill_last_w;
    logic              fill_last;
    logic [4:0]        fill_lo;
    logic [WORD_W-1:0] fill_mask;

    logic [WORD_W-1:0] mark_bit;
    logic              out_free;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fdb_reg <= FDB_RESET;
            lim_reg <= LIM_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                CFG_IDX_FDB: fdb_reg <= pwdata[FDB_W-1:0];
                CFG_IDX_LIM: lim_reg <= pwdata[LIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_IDX_FDB: prdata = PDATA_W'(fdb_reg);
            CFG_IDX_LIM: prdata = PDATA_W'(lim_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // derived values
    // ---------------------------------------------------------------
    // limit clamped to the map size
    assign lim_ext = POS_W'(lim_reg);
    assign lim_eff = (lim_ext > POS_W'(NUM_BLOCKS)) ? POS_W'(NUM_BLOCKS) : lim_ext;
    assign fdb_pos = POS_W'(fdb_reg);
    assign idx_pos = POS_W'(idx_reg);

    assign want_sat = (s_data.run_wanted > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN)
                                                           : s_data.run_wanted;

    // no candidate start at all: nothing to read
    assign start_none = (fdb_pos + POS_W'(1)) >= lim_eff;
    assign idx_in_map = idx_pos < POS_W'(NUM_BLOCKS);

    assign chunk_base = {pos_reg[POS_W-1:3], 3'b000};
    assign chunk_free = ~q_reg[{pos_reg[4:3], 3'b000} +: CHUNK_W];

    bbra_chunk_scan #(
        .POS_W (POS_W)
    ) u_chunk (
        .chunk_base     (chunk_base),
        .first_off      (pos_reg[2:0]),
        .free_bits      (chunk_free),
        .lim            (lim_eff),
        .want           (want_reg),
        .run_len_in     (run_len_reg),
        .run_start_in   (run_start_reg),
        .best_in        (best_reg),
        .best_start_in  (best_start_reg),
        .run_len_out    (cs_run_len),
        .run_start_out  (cs_run_start),
        .best_out       (cs_best),
        .best_start_out (cs_best_start),
        .done           (cs_done)
    );

    // granted run spans from best_start to fill_end, up to three words
    assign fill_end     = best_start_reg + POS_W'(best_reg) - POS_W'(1);
    assign fill_first_w = best_start_reg[ADDR_W+4:5];
    assign fill_last_w  = fill_end[ADDR_W+4:5];
    assign fill_last    = wa_reg == fill_last_w;
    assign fill_lo      = (wa_reg == fill_first_w) ? best_start_reg[4:0] : 5'd0;
    assign fill_mask    = ({WORD_W{1'b1}} << fill_lo)
                        & (fill_last ? ({WORD_W{1'b1}} >> (5'd31 - fill_end[4:0]))
                                     : {WORD_W{1'b1}});

    assign mark_bit = WORD_W'(1) << idx_reg[4:0];

    // output register is free, or is emptied in this cycle
    assign out_free = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(MAP_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (func_reg == FUNC_ALLOC) begin
                    state_next = (want_reg == '0 || start_none) ? ST_DONE : ST_SCAN;
                end else if (func_reg == FUNC_MARK_USED || func_reg == FUNC_MARK_FREE) begin
                    state_next = idx_in_map ? ST_MARK_WB : ST_DONE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (cs_done) begin
                    state_next = (cs_best != '0) ? ST_FILL_RD : ST_DONE;
                end
            end
            ST_FILL_RD: state_next = ST_FILL_WB;
            ST_FILL_WB: begin
                if (fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK_WB: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // datapath and memory control
    // ---------------------------------------------------------------
    always_comb begin
        s_ready         = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        clr_addr_next   = clr_addr_reg;
        func_next       = func_reg;
        want_next       = want_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        best_next       = best_reg;
        best_start_next = best_start_reg;
        wa_next         = wa_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                // sweep every word to all free
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                s_ready   = 1'b1;
                func_next = s_data.func;
                want_next = want_sat;
                idx_next  = s_data.block_index;
            end
            ST_START: begin
                res_next.status      = STAT_NONE;
                res_next.start_block = '0;
                res_next.run_granted = '0;
                run_len_next         = '0;
                run_start_next       = '0;
                best_next            = '0;
                best_start_next      = '0;
                pos_next             = fdb_pos;
                if (func_reg == FUNC_ALLOC) begin
                    if (want_reg == '0) begin
                        res_next.status = STAT_FULL;
                    end else if (!start_none) begin
                        mem_re    = 1'b1;
                        mem_raddr = fdb_pos[ADDR_W+4:5];
                    end
                end else if (func_reg == FUNC_MARK_USED || func_reg == FUNC_MARK_FREE) begin
                    // out of map marks still report done with the index
                    res_next.status      = STAT_FULL;
                    res_next.start_block = idx_reg;
                    if (idx_in_map) begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_pos[ADDR_W+4:5];
                    end
                end
            end
            ST_SCAN: begin
                run_len_next    = cs_run_len;
                run_start_next  = cs_run_start;
                best_next       = cs_best;
                best_start_next = cs_best_start;
                pos_next        = chunk_base + POS_W'(CHUNK_W);
                // fetch the next word while the last chunk of this one runs
                if (!cs_done && pos_reg[4:3] == 2'b11) begin
                    mem_re    = 1'b1;
                    mem_raddr = pos_reg[ADDR_W+4:5] + ADDR_W'(1);
                end
                if (cs_done) begin
                    res_next.status      = (cs_best == '0) ? STAT_NONE
                                         : (cs_best == want_reg) ? STAT_FULL : STAT_SHORT;
                    res_next.start_block = (cs_best == '0) ? '0 : cs_best_start[IDX_W-1:0];
                    res_next.run_granted = cs_best;
                end
            end
            ST_FILL_RD: begin
                mem_re    = 1'b1;
                mem_raddr = fill_first_w;
                wa_next   = fill_first_w;
            end
            ST_FILL_WB: begin
                mem_we    = 1'b1;
                mem_waddr = wa_reg;
                mem_wdata = q_reg | fill_mask;
                if (!fill_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = wa_reg + ADDR_W'(1);
                    wa_next   = wa_reg + ADDR_W'(1);
                end
            end
            ST_MARK_WB: begin
                mem_we    = 1'b1;
                mem_waddr = idx_pos[ADDR_W+4:5];
                mem_wdata = (func_reg == FUNC_MARK_USED) ? (q_reg | mark_bit)
                                                         : (q_reg & ~mark_bit);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        want_reg       <= want_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        best_reg       <= best_next;
        best_start_reg <= best_start_next;
        wa_reg         <= wa_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

    // bitmap memory, registered read, read data held between reads
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            q_reg <= mem[mem_raddr];
        end
    end

endmodule

// ===== rtl/bbra_chunk_scan.sv =====
module bbra_chunk_scan #(
    parameter int POS_W = 14
) (
    input  logic [POS_W-1:0]            chunk_base,
    input  logic [2:0]                  first_off,
    input  logic [bbra_pkg::CHUNK_W-1:0] free_bits,
    input  logic [POS_W-1:0]            lim,
    input  logic [bbra_pkg::RUN_W-1:0]  want,
    input  logic [bbra_pkg::RUN_W-1:0]  run_len_in,
    input  logic [POS_W-1:0]            run_start_in,
    input  logic [bbra_pkg::RUN_W-1:0]  best_in,
    input  logic [POS_W-1:0]            best_start_in,
    output logic [bbra_pkg::RUN_W-1:0]  run_len_out,
    output logic [POS_W-1:0]            run_start_out,
    output logic [bbra_pkg::RUN_W-1:0]  best_out,
    output logic [POS_W-1:0]            best_start_out,
    output logic                        done
);
    import bbra_pkg::*;

    // one block per step, eight dependent steps over narrow run counters
    always_comb begin
        logic [RUN_W-1:0] t;
        logic [RUN_W-1:0] bl;
        logic [POS_W-1:0] rs;
        logic [POS_W-1:0] bs;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] nb;
        logic             dn;
        logic             in_lim;
        logic             cand_ok;
        t  = run_len_in;
        rs = run_start_in;
        bl = best_in;
        bs = best_start_in;
        dn = 1'b0;
        for (int i = 0; i < CHUNK_W; i++) begin
            p       = chunk_base + POS_W'(i);
            in_lim  = p < lim;
            cand_ok = (p + POS_W'(1)) < lim;
            if (!dn && (3'(i) >= first_off)) begin
                if (!in_lim || (t == '0 && !cand_ok)) begin
                    // past the limit, or no room for a new start
                    if (t > bl) begin
                        bl = t;
                        bs = rs;
                    end
                    dn = 1'b1;
                end else if (free_bits[i]) begin
                    if (t == '0) begin
                        rs = p;
                    end
                    t = t + RUN_W'(1);
                    if (t == want) begin
                        bl = t;
                        bs = rs;
                        dn = 1'b1;
                    end
                end else begin
                    // used block ends the run, skip past it
                    if (t > bl) begin
                        bl = t;
                        bs = rs;
                    end
                    t = '0;
                end
            end
        end
        // the next chunk would start at or past the limit
        nb = chunk_base + POS_W'(CHUNK_W);
        if (!dn && nb >= lim) begin
            if (t > bl) begin
                bl = t;
                bs = rs;
            end
            dn = 1'b1;
        end
        run_len_out    = t;
        run_start_out  = rs;
        best_out       = bl;
        best_start_out = bs;
        done           = dn;
    end

endmodule

// ===== verif/bitmap_block_run_allocator_tb.sv =====
`timescale 1ns / 100ps

module bitmap_block_run_allocator_tb;

    import bbra_pkg::*;

    // ------------------------------------------------------------------
    // run constants
    // ------------------------------------------------------------------
    localparam int unsigned NUM_BLK     = DEF_NUM_BLOCKS;
    // watchdog limit, several times the slowest legal run including stalls
    // and the clear pass
    localparam int unsigned CYCLE_LIMIT = 5000000;
    // long receiver hold-off so the output register and input both fill up
    localparam int unsigned HOLD_CYCLES = 600;
    // grace period after the last result, longer than the longest scan
    localparam int unsigned END_SETTLE  = 600;
    // the one func code the package leaves unnamed
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        int unsigned first;
        int unsigned count;
    } block_run_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports, all driven from time zero
    // ------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bitmap_block_run_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // shadow of the allocator: bitmap, window registers, granted runs
    // ------------------------------------------------------------------
    bit [NUM_BLK-1:0]      used_map   = '0;
    logic [FDB_W-1:0]      cfg_first  = FDB_RESET;
    logic [LIM_CFG_W-1:0]  cfg_limit  = LIM_RESET;
    block_run_t            live_runs[$];
    out_t                  pending_outcomes[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // traffic shaping knobs
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_go    = 1'b0;
    bit rx_hold    = 1'b0;

    // outcome of one accepted beat; commits the bitmap change as well
    function automatic out_t allocator_outcome(input in_t item);
        out_t        res;
        int unsigned lim, want, cand, span, best, best_start;
        res        = '0;
        res.status = STAT_NONE;
        best       = 0;
        best_start = 0;
        case (item.func)
            FUNC_ALLOC: begin
                lim  = (cfg_limit > NUM_BLK) ? NUM_BLK : cfg_limit;
                want = (item.run_wanted > MAX_RUN) ? MAX_RUN : item.run_wanted;
                cand = cfg_first;
                if (want == 0) begin
                    res.status = STAT_FULL;
                end else begin
                    // first fit: count free blocks at each candidate, jump
                    // past whatever ended the count
                    while (cand + 1 < lim) begin
                        span = 0;
                        while (span < want && cand + span < lim && !used_map[cand + span])
                            span++;
                        if (span > best) begin
                            best       = span;
                            best_start = cand;
                        end
                        if (span == want)
                            break;
                        cand += span + 1;
                    end
                    if (best > 0) begin
                        for (int b = 0; b < best; b++)
                            used_map[best_start + b] = 1'b1;
                        res.status      = (best == want) ? STAT_FULL : STAT_SHORT;
                        res.start_block = IDX_W'(best_start);
                        res.run_granted = RUN_W'(best);
                        live_runs.push_back('{best_start, best});
                    end
                end
            end
            FUNC_MARK_USED, FUNC_MARK_FREE: begin
                used_map[item.block_index] = (item.func == FUNC_MARK_USED);
                res.status      = STAT_FULL;
                res.start_block = item.block_index;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic in_t make_item(input logic [FUNC_W-1:0] func,
                                      input int unsigned want, input int unsigned idx);
        in_t item;
        item.func        = func;
        item.run_wanted  = RUN_W'(want);
        item.block_index = IDX_W'(idx);
        return item;
    endfunction

    // mostly short runs, some long, some past the saturation point, rare zero
    function automatic int unsigned random_run_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(8, 1);
        if (r < 80)
            return $urandom_range(32, 9);
        if (r < 93)
            return $urandom_range(64, 33);
        if (r < 98)
            return $urandom_range(127, 65);
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                 what, exp_val, got_val, cycle_count);
        error_count++;
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat, start_block", 0, got.start_block);
            return;
        end
        want = pending_outcomes.pop_front();
        if (got.status != want.status)
            report_mismatch("status", want.status, got.status);
        if (got.start_block != want.start_block)
            report_mismatch("start_block", want.start_block, got.start_block);
        if (got.run_granted != want.run_granted)
            report_mismatch("run_granted", want.run_granted, got.run_granted);
    endtask

    // ------------------------------------------------------------------
    // result side: check each beat, then pick the next m_ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result(m_data);
        m_ready <= !rx_hold && (!rx_idle_on || $urandom_range(99) >= 33);
    end

    // long hold-off, counted here so the sender keeps pushing meanwhile
    initial begin
        forever begin
            wait (hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
            wait (!hold_go);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // one beat; valid is left high on return so back-to-back beats need no
    // bubble, and the expectation is formed at the accepting edge
    task automatic send_item(input in_t item);
        if (tx_idle_on && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(allocator_outcome(item));
    endtask

    // sender goes quiet until every result is back
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    // apb write with a read back of the same register
    task automatic write_register(input logic reg_idx, input int unsigned value);
        logic [PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_idx == CFG_IDX_FDB)
            cfg_first = FDB_W'(value);
        else
            cfg_limit = LIM_CFG_W'(value);
        // read phase on the same select
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        if (reg_idx == CFG_IDX_FDB) begin
            if (readback != PDATA_W'(cfg_first))
                report_mismatch("first_data_block read back", cfg_first, readback);
        end else begin
            if (readback != PDATA_W'(cfg_limit))
                report_mismatch("block_limit read back", cfg_limit, readback);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // registers only change with the block idle
    task automatic set_window(input int unsigned first, input int unsigned limit);
        wait_all_results();
        write_register(CFG_IDX_FDB, first);
        write_register(CFG_IDX_LIM, limit);
    endtask

    // one random operation; freeing a granted run sends one beat per block
    task automatic send_random_op(output int unsigned sent);
        in_t         item;
        block_run_t  victim;
        int unsigned pick, lo, hi, slot;
        pick             = $urandom_range(99);
        lo               = cfg_first;
        hi               = (cfg_limit > NUM_BLK) ? NUM_BLK : cfg_limit;
        item.func        = FUNC_ALLOC;
        item.run_wanted  = RUN_W'($urandom);
        item.block_index = IDX_W'($urandom);
        sent             = 1;
        if (pick < 30 && live_runs.size() != 0) begin
            // hand back an earlier grant block by block, leaving holes behind
            slot   = $urandom_range(live_runs.size() - 1);
            victim = live_runs[slot];
            live_runs.delete(slot);
            item.func = FUNC_MARK_FREE;
            for (int b = 0; b < victim.count; b++) begin
                item.block_index = IDX_W'(victim.first + b);
                item.run_wanted  = RUN_W'($urandom);
                send_item(item);
            end
            sent = victim.count;
        end else if (pick < 75) begin
            item.run_wanted = RUN_W'(random_run_len());
            send_item(item);
        end else if (pick < 92) begin
            // single marks inside the search window fragment it
            item.func = ($urandom_range(1) != 0) ? FUNC_MARK_USED : FUNC_MARK_FREE;
            if (hi > lo)
                item.block_index = IDX_W'($urandom_range(hi - 1, lo));
            send_item(item);
        end else if (pick < 96) begin
            item.func = FUNC_UNUSED;
            send_item(item);
        end else begin
            // marks anywhere in the block space
            item.func = ($urandom_range(1) != 0) ? FUNC_MARK_USED : FUNC_MARK_FREE;
            send_item(item);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // default window: full runs, saturation, zero length, marks at the ends
    task automatic test_directed();
        send_item(make_item(FUNC_ALLOC, 1, 0));
        send_item(make_item(FUNC_ALLOC, MAX_RUN, 0));
        send_item(make_item(FUNC_ALLOC, 127, 4095));
        send_item(make_item(FUNC_ALLOC, 0, 0));
        send_item(make_item(FUNC_UNUSED, 127, 4095));
        send_item(make_item(FUNC_MARK_USED, 0, 0));
        send_item(make_item(FUNC_MARK_USED, 0, NUM_BLK - 1));
        send_item(make_item(FUNC_MARK_FREE, 127, NUM_BLK - 1));
        send_item(make_item(FUNC_MARK_FREE, 0, 0));
        // a used block just ahead of the search makes it skip the short hole
        send_item(make_item(FUNC_MARK_USED, 1, 140));
        send_item(make_item(FUNC_ALLOC, 20, 0));
    endtask

    // empty windows, short grants, limit above the block count
    task automatic test_limit_cases();
        set_window(0, 0);
        send_item(make_item(FUNC_ALLOC, 5, 0));
        set_window(0, 1);
        send_item(make_item(FUNC_ALLOC, 5, 0));
        set_window(FDB_W'('1), NUM_BLK);
        send_item(make_item(FUNC_ALLOC, 1, 0));
        set_window(100, 50);
        send_item(make_item(FUNC_ALLOC, 1, 0));
        set_window(0, 8);
        send_item(make_item(FUNC_ALLOC, 3, 0));
        send_item(make_item(FUNC_ALLOC, MAX_RUN, 0));
        send_item(make_item(FUNC_MARK_FREE, 0, 5));
        send_item(make_item(FUNC_ALLOC, 1, 0));
        set_window(0, 8191);
        send_item(make_item(FUNC_ALLOC, MAX_RUN, 0));
    endtask

    // random traffic across a series of windows; phase 2 runs with no idling
    task automatic test_random_phases();
        int unsigned sent, done, first, limit, beats;
        for (int p = 0; p < 13; p++) begin
            case (p)
                0:  begin first = 0;    limit = 4096; beats = 150; end
                1:  begin first = 2;    limit = 4096; beats = 100; end
                2:  begin first = 0;    limit = 64;   beats = 300; end
                3:  begin first = 37;   limit = 200;  beats = 300; end
                4:  begin first = 1000; limit = 1300; beats = 300; end
                5:  begin first = 3900; limit = 8191; beats = 250; end
                6:  begin first = 4095; limit = 4096; beats = 20;  end
                7:  begin first = 500;  limit = 100;  beats = 20;  end
                8:  begin first = 0;    limit = 0;    beats = 20;  end
                9:  begin first = 0;    limit = 1;    beats = 20;  end
                10: begin first = 0;    limit = 2;    beats = 40;  end
                11: begin first = 10;   limit = 40;   beats = 200; end
                default: begin first = 4032; limit = 4096; beats = 150; end
            endcase
            set_window(first, limit);
            tx_idle_on = (p != 2);
            rx_idle_on <= (p != 2);
            done = 0;
            while (done < beats) begin
                send_random_op(sent);
                done += sent;
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    // receiver stops for a long stretch while the sender keeps offering
    task automatic test_output_hold();
        int unsigned sent, done;
        set_window(0, 96);
        tx_idle_on = 1'b0;
        hold_go <= 1'b1;
        done = 0;
        while (done < 24) begin
            send_random_op(sent);
            done += sent;
        end
        wait_all_results();
        hold_go <= 1'b0;
        tx_idle_on = 1'b1;
    endtask

    // short bursts, each followed by a full drain
    task automatic test_sender_pause();
        int unsigned sent, done;
        set_window(3, 130);
        repeat (4) begin
            done = 0;
            while (done < 8) begin
                send_random_op(sent);
                done += sent;
            end
            wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // the clear pass after reset holds s_ready low; send_item waits it out
        test_directed();
        test_limit_cases();
        test_random_phases();
        test_output_hold();
        test_sender_pause();
        wait_all_results();
        // anything arriving now is a stray beat and gets flagged by the checker
        repeat (END_SETTLE) @(posedge aclk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bbra_pkg.sv
rtl/bbra_chunk_scan.sv
rtl/bitmap_block_run_allocator.sv
verif/bitmap_block_run_allocator_tb.sv
